@@ src/sfd_pkg.sv @@
// Shared constants and types for the sensor frame deframer.
// No dependencies; the configuration interface, parser, drain and top level import it.
`timescale 1ns / 1ps

package sfd_pkg;

  // Default frame geometry
  localparam int MAX_SENSORS_DEF      = 15;
  localparam int BYTES_PER_SENSOR_DEF = 4;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // Drop reasons
  localparam logic [2:0] RSN_NONE      = 3'd0;
  localparam logic [2:0] RSN_COUNT_BIG = 3'd1;
  localparam logic [2:0] RSN_ERR_COUNT = 3'd2;
  localparam logic [2:0] RSN_ERR_DATA  = 3'd3;
  localparam logic [2:0] RSN_END_BAD   = 3'd4;

  // Parser to drain sequencer: immediate result and drain request
  typedef struct packed {
    logic       res_valid;
    logic [1:0] kind;
    logic [2:0] reason;
    logic       drain_start;
  } par_evt_t;

  // Drain sequencer status back to the parser
  typedef struct packed {
    logic busy;
    logic slot_free;
  } drn_stat_t;

endpackage

@@ src/sfd_in_if.sv @@
// Received byte channel: valid/ready with one byte and its line-error flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_error;

  modport source (output valid, rx_byte, line_error, input ready);
  modport sink   (input valid, rx_byte, line_error, output ready);
endinterface

@@ src/sfd_out_if.sv @@
// Result channel: valid/ready with one result beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  drop_reason;
  logic [3:0]  sensor_index;
  logic [31:0] sensor_word;
  logic        last_result;

  modport source (output valid, result_kind, drop_reason, sensor_index, sensor_word,
                  last_result, input ready);
  modport sink   (input valid, result_kind, drop_reason, sensor_index, sensor_word,
                  last_result, output ready);
endinterface

@@ src/sfd_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on sfd_pkg for the index width.
`timescale 1ns / 1ps

interface sfd_cfg_if import sfd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sensor_frame_deframer.sv @@
// Sensor frame deframer top level: parser, frame store RAM, drain sequencer.
// A drop or empty result is shown the cycle after its byte; words follow an
// accepted end flag via the drain start, store read and result registers,
// then one word per cycle while the result channel is ready. Input: one byte
// per cycle while the result slot is free; a later byte of a word stalls
// input for the store read-modify-write, the end flag while the drain reads
// the store. Synchronous reset clears control state and flags, not the store.
`timescale 1ns / 1ps

module sensor_frame_deframer import sfd_pkg::*; #(
  parameter int MAX_SENSORS      = MAX_SENSORS_DEF,
  parameter int BYTES_PER_SENSOR = BYTES_PER_SENSOR_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sfd_in_if.sink    rx,
  sfd_cfg_if.sink   cfg,
  sfd_out_if.source res
);

  localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CW = $clog2(MAX_SENSORS + 1);
  localparam int WW = 8 * BYTES_PER_SENSOR;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic          par_re;
  logic [AW-1:0] par_raddr;
  logic          drn_re;
  logic [AW-1:0] drn_raddr;
  par_evt_t      evt;
  drn_stat_t     drn;
  logic [CW-1:0] frame_count;

  sfd_parser #(
    .MAX_SENSORS      (MAX_SENSORS),
    .BYTES_PER_SENSOR (BYTES_PER_SENSOR)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .cfg         (cfg),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (par_re),
    .ram_raddr   (par_raddr),
    .ram_rdata   (ram_rdata),
    .evt         (evt),
    .frame_count (frame_count),
    .drn         (drn)
  );

  // Share the read port: the drain only runs while the parser is stalled
  assign ram_re    = par_re || drn_re;
  assign ram_raddr = drn_re ? drn_raddr : par_raddr;

  sfd_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_SENSORS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfd_drain #(
    .MAX_SENSORS      (MAX_SENSORS),
    .BYTES_PER_SENSOR (BYTES_PER_SENSOR)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .frame_count (frame_count),
    .ram_re      (drn_re),
    .ram_raddr   (drn_raddr),
    .ram_rdata   (ram_rdata),
    .drn         (drn),
    .res         (res)
  );

  // Parser and drain never touch the store in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(drn_re && (par_re || ram_we)))
    else $error("frame store accessed by parser and drain together");

  // A merge read is always followed by its write-back
  a_rmw_write: assert property (@(posedge clk) disable iff (rst)
    par_re |=> ram_we)
    else $error("merge read not followed by write-back");

  // No byte is taken while buffered words are still going out
  a_no_accept_drain: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |-> !drn.busy)
    else $error("byte accepted during drain");

  // Drop and empty results always close their byte's results
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.result_kind == KIND_DROP || res.result_kind == KIND_EMPTY))
      |-> res.last_result)
    else $error("drop or empty result without last mark");

endmodule

@@ src/sfd_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sfd_parser.sv @@
// Frame parser: phase tracking, configuration registers and byte packing
// into the frame store by read-modify-write. Depends on sfd_pkg and interfaces.
`timescale 1ns / 1ps

module sfd_parser import sfd_pkg::*; #(
  parameter int MAX_SENSORS      = MAX_SENSORS_DEF,
  parameter int BYTES_PER_SENSOR = BYTES_PER_SENSOR_DEF,
  localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1,
  localparam int CW = $clog2(MAX_SENSORS + 1),
  localparam int BW = (BYTES_PER_SENSOR > 1) ? $clog2(BYTES_PER_SENSOR) : 1,
  localparam int WW = 8 * BYTES_PER_SENSOR
) (
  input  logic          clk,
  input  logic          rst,
  sfd_in_if.sink        rx,
  sfd_cfg_if.sink       cfg,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [WW-1:0] ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [WW-1:0] ram_rdata,
  output par_evt_t      evt,
  output logic [CW-1:0] frame_count,
  input  drn_stat_t     drn
);

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  localparam logic [BW-1:0] BP_LAST = BW'(BYTES_PER_SENSOR - 1);
  localparam logic [7:0]    MAX_B   = 8'(MAX_SENSORS);

  logic [7:0]    open_byte;
  logic [7:0]    close_byte;
  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic [CW-1:0] sensor_count;
  logic [CW-1:0] word_pos;
  logic [BW-1:0] byte_pos;
  logic          rmw_pend;
  logic [7:0]    mod_byte;
  logic [BW-1:0] mod_bp;
  logic [AW-1:0] mod_addr;
  logic          acc;
  logic [7:0]    b;
  logic          err;
  logic [CW-1:0] word_pos_inc;
  logic          data_ok;

  assign b   = rx.rx_byte;
  assign err = rx.line_error;

  // Take a byte only with nothing in flight and room for its result
  assign rx.ready = !rmw_pend && !drn.busy && drn.slot_free;
  assign acc      = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  assign word_pos_inc = word_pos + 1'b1;
  assign data_ok      = acc && (phase == PH_DATA) && !err;
  assign frame_count  = sensor_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_byte  <= '0;
      close_byte <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_FLAG: open_byte  <= cfg.data;
        CFG_END_FLAG:   close_byte <= cfg.data;
        default: ;
      endcase
    end
  end

  // Phase decode and immediate results
  always_comb begin
    phase_next      = phase;
    evt.res_valid   = 1'b0;
    evt.kind        = KIND_DROP;
    evt.reason      = RSN_NONE;
    evt.drain_start = 1'b0;
    if (acc) begin
      unique case (phase)
        PH_WAIT: begin
          if (!err && b == open_byte) phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (err) begin
            phase_next    = PH_WAIT;
            evt.res_valid = 1'b1;
            evt.reason    = RSN_ERR_COUNT;
          end else if (b > MAX_B) begin
            phase_next    = PH_WAIT;
            evt.res_valid = 1'b1;
            evt.reason    = RSN_COUNT_BIG;
          end else begin
            phase_next = (b == 8'd0) ? PH_END : PH_DATA;
          end
        end
        PH_DATA: begin
          if (err) begin
            phase_next    = PH_WAIT;
            evt.res_valid = 1'b1;
            evt.reason    = RSN_ERR_DATA;
          end else if (byte_pos == BP_LAST && word_pos_inc >= sensor_count) begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          phase_next = PH_WAIT;
          if (err || b != close_byte) begin
            evt.res_valid = 1'b1;
            evt.reason    = RSN_END_BAD;
          end else if (sensor_count == '0) begin
            evt.res_valid = 1'b1;
            evt.kind      = KIND_EMPTY;
          end else begin
            evt.drain_start = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Phase and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      sensor_count <= '0;
      word_pos     <= '0;
      byte_pos     <= '0;
      rmw_pend     <= 1'b0;
    end else begin
      phase    <= phase_next;
      rmw_pend <= data_ok && (byte_pos != '0);
      if (acc && phase == PH_COUNT && !err && b <= MAX_B) begin
        sensor_count <= CW'(b);
        word_pos     <= '0;
        byte_pos     <= '0;
      end else if (data_ok) begin
        if (byte_pos == BP_LAST) begin
          byte_pos <= '0;
          word_pos <= word_pos_inc;
        end else begin
          byte_pos <= byte_pos + 1'b1;
        end
      end
    end
  end

  // Hold the byte for the modify cycle
  always_ff @(posedge clk) begin
    if (data_ok) begin
      mod_byte <= b;
      mod_bp   <= byte_pos;
      mod_addr <= word_pos[AW-1:0];
    end
  end

  // Frame store access: first byte of a word overwrites, later bytes merge
  assign ram_re    = data_ok && (byte_pos != '0);
  assign ram_raddr = word_pos[AW-1:0];
  assign ram_we    = (data_ok && byte_pos == '0) || rmw_pend;
  assign ram_waddr = rmw_pend ? mod_addr : word_pos[AW-1:0];
  assign ram_wdata = rmw_pend ? (ram_rdata | (WW'(mod_byte) << {mod_bp, 3'b000}))
                              : WW'(b);

endmodule

@@ src/sfd_drain.sv @@
// Drain sequencer and result register: reads buffered words out in order
// and holds one result beat. Depends on sfd_pkg and sfd_out_if.
`timescale 1ns / 1ps

module sfd_drain import sfd_pkg::*; #(
  parameter int MAX_SENSORS      = MAX_SENSORS_DEF,
  parameter int BYTES_PER_SENSOR = BYTES_PER_SENSOR_DEF,
  localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1,
  localparam int CW = $clog2(MAX_SENSORS + 1),
  localparam int WW = 8 * BYTES_PER_SENSOR
) (
  input  logic          clk,
  input  logic          rst,
  input  par_evt_t      evt,
  input  logic [CW-1:0] frame_count,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [WW-1:0] ram_rdata,
  output drn_stat_t     drn,
  sfd_out_if.source     res
);

  logic          draining;
  logic [CW-1:0] k;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] cnt;
  logic          dv;
  logic [CW-1:0] dv_idx;
  logic          dv_last;
  logic          slot_free;
  logic          move;
  logic          issue;
  logic [CW+3:0] idx_ext;
  logic [WW+31:0] word_ext;

  assign k_inc     = k + 1'b1;
  assign slot_free = !res.valid || res.ready;
  assign move      = dv && slot_free;
  assign issue     = draining && (!dv || move);

  assign ram_re    = issue;
  assign ram_raddr = k[AW-1:0];

  assign drn.busy      = draining || dv;
  assign drn.slot_free = slot_free;

  assign idx_ext  = {4'b0000, dv_idx};
  assign word_ext = {32'd0, ram_rdata};

  // Read sequencer; the RAM read register acts as a skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      k        <= '0;
      cnt      <= '0;
      dv       <= 1'b0;
    end else begin
      if (evt.drain_start) begin
        draining <= 1'b1;
        k        <= '0;
        cnt      <= frame_count;
      end else if (issue) begin
        k <= k_inc;
        if (k_inc == cnt) draining <= 1'b0;
      end
      if (issue) dv <= 1'b1;
      else if (move) dv <= 1'b0;
    end
  end

  // Sideband of the word in the read register
  always_ff @(posedge clk) begin
    if (issue) begin
      dv_idx  <= k;
      dv_last <= (k_inc == cnt);
    end
  end

  // Result register: valid is control, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (move || evt.res_valid) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res.result_kind  <= KIND_WORD;
      res.drop_reason  <= RSN_NONE;
      res.sensor_index <= idx_ext[3:0];
      res.sensor_word  <= word_ext[31:0];
      res.last_result  <= dv_last;
    end else if (evt.res_valid) begin
      res.result_kind  <= evt.kind;
      res.drop_reason  <= evt.reason;
      res.sensor_index <= 4'd0;
      res.sensor_word  <= 32'd0;
      res.last_result  <= 1'b1;
    end
  end

endmodule
